FILE: sv/kpd_pkg.sv
`timescale 1ns / 1ps

package kpd_pkg;

    // Keypad geometry
    localparam int ROWS      = 4;
    localparam int ROW_W     = 2;
    localparam int COL_W     = 2;
    localparam int LINES_W   = 3;
    localparam int KEY_W     = 4;
    localparam int TAP_W     = 3;
    localparam int CHAR_W    = 7;
    localparam int DEB_W     = 8;
    localparam int IDLE_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [KEY_W-1:0]   NO_KEY     = 4'hF;
    localparam logic [LINES_W-1:0] LINES_IDLE = 3'b111;
    localparam logic [DEB_W-1:0]   DEB_MAX    = 8'hFF;
    localparam logic [IDLE_W-1:0]  IDLE_MAX   = 12'hFFF;
    localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(ROWS - 1);

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd25;
    localparam logic [IDLE_W-1:0] COMMIT_RESET   = 12'd200;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMIT   = 1'b1;

    // Scanner phases
    typedef enum logic [1:0] {
        PH_SCAN      = 2'd0,
        PH_DEB_PRESS = 2'd1,
        PH_WAIT_REL  = 2'd2,
        PH_DEB_REL   = 2'd3
    } kpd_phase_t;

    // One result item
    typedef struct packed {
        logic [ROW_W-1:0]  row_select;
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
    } kpd_result_t;

    // First letter on a key, zero for keys without letters
    function automatic logic [CHAR_W-1:0] letter_base(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] c;
        case (key)
            4'd1:    c = 7'h61; // a
            4'd2:    c = 7'h64; // d
            4'd3:    c = 7'h67; // g
            4'd4:    c = 7'h6A; // j
            4'd5:    c = 7'h6D; // m
            4'd6:    c = 7'h70; // p
            4'd7:    c = 7'h74; // t
            4'd8:    c = 7'h77; // w
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Digit or symbol printed on a key
    function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] c;
        case (key)
            4'd0:    c = 7'h31; // 1
            4'd1:    c = 7'h32;
            4'd2:    c = 7'h33;
            4'd3:    c = 7'h34;
            4'd4:    c = 7'h35;
            4'd5:    c = 7'h36;
            4'd6:    c = 7'h37;
            4'd7:    c = 7'h38;
            4'd8:    c = 7'h39;
            4'd9:    c = 7'h2A; // *
            4'd10:   c = 7'h30; // 0
            4'd11:   c = 7'h23; // #
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/kpd_in_if.sv
`timescale 1ns / 1ps

interface kpd_in_if;
    logic                           valid;
    logic                           ready;
    logic [kpd_pkg::LINES_W-1:0]    column_lines;

    modport source (output valid, output column_lines, input ready);
    modport sink   (input valid, input column_lines, output ready);
endinterface

FILE: sv/kpd_out_if.sv
`timescale 1ns / 1ps

interface kpd_out_if;
    logic                           valid;
    logic                           ready;
    logic [kpd_pkg::ROW_W-1:0]      row_select;
    logic                           char_valid;
    logic [kpd_pkg::CHAR_W-1:0]     char_code;

    modport source (output valid, output row_select, output char_valid,
                    output char_code, input ready);
    modport sink   (input valid, input row_select, input char_valid,
                    input char_code, output ready);
endinterface

FILE: sv/kpd_multitap.sv
`timescale 1ns / 1ps

module kpd_multitap (
    input  logic [kpd_pkg::KEY_W-1:0]  key,
    input  logic [kpd_pkg::KEY_W-1:0]  last_key,
    input  logic [kpd_pkg::TAP_W-1:0]  press_count,
    output logic [kpd_pkg::TAP_W-1:0]  press_count_next,
    output logic [kpd_pkg::CHAR_W-1:0] char_code
);
    import kpd_pkg::*;

    logic             four_letter;
    logic [TAP_W-1:0] tap_last;
    logic [TAP_W-1:0] letters;

    // 7 and 9 keys carry four letters and cycle over five taps
    assign four_letter = (key == 4'd6) || (key == 4'd8);
    assign tap_last    = four_letter ? 3'd4 : 3'd3;

    always_comb
    begin
        if (four_letter)
            letters = 3'd4;
        else if ((key >= 4'd1) && (key <= 4'd7))
            letters = 3'd3;
        else
            letters = 3'd0;
    end

    // Tap count: fresh key restarts, same key wraps
    always_comb
    begin
        if (key != last_key)
            press_count_next = '0;
        else if (press_count >= tap_last)
            press_count_next = '0;
        else
            press_count_next = press_count + 3'd1;
    end

    // Letter while taps remain on the key, then the digit
    always_comb
    begin
        if (key > 4'd11)
            char_code = '0;
        else if ((letters != '0) && (press_count_next < letters))
            char_code = letter_base(key) + CHAR_W'(press_count_next);
        else
            char_code = plain_char(key);
    end

endmodule

FILE: sv/kpd_ctrl.sv
`timescale 1ns / 1ps

module kpd_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [kpd_pkg::LINES_W-1:0]    column_lines,
    input  logic [kpd_pkg::DEB_W-1:0]      debounce_ticks,
    input  logic [kpd_pkg::IDLE_W-1:0]     commit_ticks,
    output kpd_pkg::kpd_result_t           result
);
    import kpd_pkg::*;

    kpd_phase_t        phase_reg, phase_next;
    logic [ROW_W-1:0]  row_index_reg, row_index_next;
    logic [COL_W-1:0]  latched_column_reg, latched_column_next;
    logic [DEB_W-1:0]  debounce_count_reg, debounce_count_next;
    logic [IDLE_W-1:0] idle_count_reg, idle_count_next;
    logic [KEY_W-1:0]  last_key_reg, last_key_next;
    logic [TAP_W-1:0]  press_count_reg, press_count_next;

    logic              pressed;
    logic              commit_due;
    logic [DEB_W-1:0]  deb_inc;
    logic              deb_done;
    logic [KEY_W-1:0]  key;
    logic [TAP_W-1:0]  tap_next;
    logic [CHAR_W-1:0] tap_code;

    assign pressed    = (column_lines != LINES_IDLE);
    assign commit_due = (last_key_reg != NO_KEY) && (idle_count_reg >= commit_ticks);
    assign deb_inc    = (debounce_count_reg == DEB_MAX) ? DEB_MAX
                                                        : debounce_count_reg + 8'd1;
    assign deb_done   = (deb_inc >= debounce_ticks);
    assign key        = KEY_W'({2'b00, row_index_reg} * 4'd3) + {2'b00, latched_column_reg};

    kpd_multitap u_multitap (
        .key              (key),
        .last_key         (last_key_reg),
        .press_count      (press_count_reg),
        .press_count_next (tap_next),
        .char_code        (tap_code)
    );

    // Phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SCAN:
                if (!commit_due && pressed)
                    phase_next = PH_DEB_PRESS;
            PH_DEB_PRESS:
                if (deb_done)
                    phase_next = PH_WAIT_REL;
            PH_WAIT_REL:
                if (!pressed)
                    phase_next = PH_DEB_REL;
            PH_DEB_REL:
                if (deb_done)
                    phase_next = PH_SCAN;
        endcase
    end

    // Datapath updates and result for this transfer
    always_comb
    begin
        row_index_next      = row_index_reg;
        latched_column_next = latched_column_reg;
        debounce_count_next = debounce_count_reg;
        idle_count_next     = idle_count_reg;
        last_key_next       = last_key_reg;
        press_count_next    = press_count_reg;
        result.row_select   = row_index_reg;
        result.char_valid   = 1'b0;
        result.char_code    = '0;
        unique case (phase_reg)
            PH_SCAN:
                if (commit_due)
                begin
                    last_key_next    = NO_KEY;
                    press_count_next = '0;
                end
                else
                begin
                    if (idle_count_reg != IDLE_MAX)
                        idle_count_next = idle_count_reg + 12'd1;
                    if (pressed)
                    begin
                        // lowest pressed column wins
                        priority if (!column_lines[0])
                            latched_column_next = 2'd0;
                        else if (!column_lines[1])
                            latched_column_next = 2'd1;
                        else
                            latched_column_next = 2'd2;
                        debounce_count_next = '0;
                    end
                    else
                    begin
                        row_index_next = (row_index_reg == ROW_LAST) ? '0
                                                                     : row_index_reg + 2'd1;
                    end
                end
            PH_DEB_PRESS:
            begin
                debounce_count_next = deb_inc;
                if (deb_done)
                begin
                    last_key_next     = key;
                    press_count_next  = tap_next;
                    result.char_valid = (tap_code != '0);
                    result.char_code  = tap_code;
                end
            end
            PH_WAIT_REL:
                if (!pressed)
                    debounce_count_next = '0;
            PH_DEB_REL:
            begin
                debounce_count_next = deb_inc;
                if (deb_done)
                    idle_count_next = '0;
            end
        endcase
    end

    // State registers advance once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_SCAN;
            row_index_reg      <= '0;
            latched_column_reg <= '0;
            debounce_count_reg <= '0;
            idle_count_reg     <= '0;
            last_key_reg       <= NO_KEY;
            press_count_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            row_index_reg      <= row_index_next;
            latched_column_reg <= latched_column_next;
            debounce_count_reg <= debounce_count_next;
            idle_count_reg     <= idle_count_next;
            last_key_reg       <= last_key_next;
            press_count_reg    <= press_count_next;
        end
    end

endmodule

FILE: sv/keypad_scan_multitap_decoder_top.sv
`timescale 1ns / 1ps

// Keypad scanner with phone multi-tap text entry. Each input transfer is one
// scan tick carrying the active-low column lines of the row being driven; each
// tick yields exactly one result with the row driven that tick and, when a key
// is decoded, its letter or digit. Throughput is one tick per clock: the tick
// lands in an input register, the scanner state and decode logic update as it
// leaves, and the result sits in an output register, so a new tick is taken
// every cycle while the output is being drained. Debounce and commit timeouts
// are counted in ticks and must be written only while no tick is in flight.
module keypad_scan_multitap_decoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    kpd_in_if.sink                          in_ch,
    kpd_out_if.source                       out_ch
);
    import kpd_pkg::*;

    logic [DEB_W-1:0]   debounce_ticks_reg;
    logic [IDLE_W-1:0]  commit_ticks_reg;
    logic               s1_valid_reg;
    logic [LINES_W-1:0] s1_lines_reg;
    logic               out_valid_reg;
    kpd_result_t        out_data_reg;
    kpd_result_t        result;
    logic               fire;

    // Tick moves to the output when the result slot is free or draining
    assign fire         = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
            commit_ticks_reg   <= COMMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_ticks_reg <= cfg_data[DEB_W-1:0];
                CFG_COMMIT:   commit_ticks_reg   <= cfg_data[IDLE_W-1:0];
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            s1_lines_reg <= in_ch.column_lines;
    end

    kpd_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (fire),
        .column_lines   (s1_lines_reg),
        .debounce_ticks (debounce_ticks_reg),
        .commit_ticks   (commit_ticks_reg),
        .result         (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= result;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.row_select = out_data_reg.row_select;
    assign out_ch.char_valid = out_data_reg.char_valid;
    assign out_ch.char_code  = out_data_reg.char_code;

endmodule

FILE: bench/keypad_scan_multitap_decoder_top_tb.sv
`timescale 1ns / 1ps

module keypad_scan_multitap_decoder_top_tb;
    import kpd_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kpd_in_if  in_ch();
    kpd_out_if out_ch();

    keypad_scan_multitap_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Scanner shadow state and register copies
    kpd_phase_t         ph;
    logic [ROW_W-1:0]   row_idx;
    logic [COL_W-1:0]   lat_col;
    logic [DEB_W-1:0]   deb_cnt;
    logic [IDLE_W-1:0]  idle_cnt;
    logic [KEY_W-1:0]   last_key;
    logic [TAP_W-1:0]   taps;
    logic [DEB_W-1:0]   cfg_deb;
    logic [IDLE_W-1:0]  cfg_commit;

    kpd_result_t expected_q[$];

    bit idling_on;
    int n_fail;
    int n_ticks;
    int n_chars;
    int n_settings;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Character for a key after a given number of repeated taps
    function automatic logic [CHAR_W-1:0] multitap_char(input logic [KEY_W-1:0] key,
                                                         input logic [TAP_W-1:0] tap_no);
        logic [7:0] legend;
        logic [7:0] first;
        int         n_letters;
        case (key)
            4'd0:    begin legend = "1"; first = 8'd0; end
            4'd1:    begin legend = "2"; first = "a";  end
            4'd2:    begin legend = "3"; first = "d";  end
            4'd3:    begin legend = "4"; first = "g";  end
            4'd4:    begin legend = "5"; first = "j";  end
            4'd5:    begin legend = "6"; first = "m";  end
            4'd6:    begin legend = "7"; first = "p";  end
            4'd7:    begin legend = "8"; first = "t";  end
            4'd8:    begin legend = "9"; first = "w";  end
            4'd9:    begin legend = "*"; first = 8'd0; end
            4'd10:   begin legend = "0"; first = 8'd0; end
            4'd11:   begin legend = "#"; first = 8'd0; end
            default: begin legend = 8'd0; first = 8'd0; end
        endcase
        if (key == 4'd6 || key == 4'd8)
            n_letters = 4;
        else if (key >= 4'd1 && key <= 4'd7)
            n_letters = 3;
        else
            n_letters = 0;
        if (n_letters != 0 && int'(tap_no) < n_letters)
            legend = first + 8'(tap_no);
        return legend[CHAR_W-1:0];
    endfunction

    // Advance the shadow scanner by one tick and return its result
    function automatic kpd_result_t scan_tick(input logic [LINES_W-1:0] lines);
        kpd_result_t       r;
        logic              pressed;
        logic [KEY_W-1:0]  key;
        logic [CHAR_W-1:0] code;
        pressed = (lines != LINES_IDLE);
        code = '0;
        r.row_select = row_idx;
        case (ph)
            PH_SCAN:
            begin
                if (last_key != NO_KEY && idle_cnt >= cfg_commit)
                begin
                    // commit tick: forget the key, no scan
                    last_key = NO_KEY;
                    taps = '0;
                end
                else
                begin
                    if (idle_cnt != IDLE_MAX)
                        idle_cnt = idle_cnt + 1'b1;
                    if (pressed)
                    begin
                        if (!lines[0])
                            lat_col = 2'd0;
                        else if (!lines[1])
                            lat_col = 2'd1;
                        else
                            lat_col = 2'd2;
                        deb_cnt = '0;
                        ph = PH_DEB_PRESS;
                    end
                    else
                        row_idx = (row_idx == ROW_LAST) ? '0 : row_idx + 1'b1;
                end
            end
            PH_DEB_PRESS:
            begin
                if (deb_cnt != DEB_MAX)
                    deb_cnt = deb_cnt + 1'b1;
                if (deb_cnt >= cfg_deb)
                begin
                    key = KEY_W'(row_idx) * 4'd3 + KEY_W'(lat_col);
                    if (key != last_key)
                    begin
                        taps = '0;
                        last_key = key;
                    end
                    else if (key == 4'd6 || key == 4'd8)
                        taps = (taps == 3'd4) ? '0 : taps + 1'b1;
                    else
                        taps = (taps == 3'd3) ? '0 : taps + 1'b1;
                    code = multitap_char(key, taps);
                    ph = PH_WAIT_REL;
                end
            end
            PH_WAIT_REL:
            begin
                if (!pressed)
                begin
                    deb_cnt = '0;
                    ph = PH_DEB_REL;
                end
            end
            default:
            begin
                if (deb_cnt != DEB_MAX)
                    deb_cnt = deb_cnt + 1'b1;
                if (deb_cnt >= cfg_deb)
                begin
                    idle_cnt = '0;
                    ph = PH_SCAN;
                end
            end
        endcase
        r.char_valid = (code != '0);
        r.char_code  = code;
        return r;
    endfunction

    // Active-low lines with column col as the lowest one pressed
    function automatic logic [LINES_W-1:0] press_lines(input int col);
        logic [LINES_W-1:0] l;
        int                 b;
        l = LINES_IDLE;
        l[col] = 1'b0;
        for (b = col + 1; b < LINES_W; b++)
            if ($urandom_range(0, 1) == 1)
                l[b] = 1'b0;
        return l;
    endfunction

    // One tick transfer, with an optional idle burst in front
    task automatic send_tick(input logic [LINES_W-1:0] lines);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            repeat (gap)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.column_lines <= lines;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_q.push_back(scan_tick(lines));
        n_ticks++;
    endtask

    // Stop sending and let every result come out
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers while nothing is in flight
    task automatic set_config(input logic [DEB_W-1:0] deb, input logic [IDLE_W-1:0] commit);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= {4'($urandom_range(0, 15)), deb};
        @(negedge clk);
        cfg_index <= CFG_COMMIT;
        cfg_data  <= commit;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_deb    = deb;
        cfg_commit = commit;
        n_settings++;
    endtask

    // Full press of one key: wait for its row, hold, release, then idle
    task automatic press_key(input int key, input int hold, input bit bounce, input int gap);
        int row;
        int col;
        row = key / 3;
        col = key % 3;
        while (!(ph == PH_SCAN && int'(row_idx) == row))
            send_tick(LINES_IDLE);
        while (ph != PH_WAIT_REL)
        begin
            if (bounce && ph == PH_DEB_PRESS && $urandom_range(0, 2) == 0)
                send_tick(LINES_IDLE);
            else
                send_tick(press_lines(col));
        end
        repeat (hold) send_tick(press_lines(col));
        while (ph != PH_SCAN)
        begin
            if (bounce && ph == PH_DEB_REL && $urandom_range(0, 1) == 0)
                send_tick(LINES_W'($urandom_range(0, 7)));
            else
                send_tick(LINES_IDLE);
        end
        repeat (gap) send_tick(LINES_IDLE);
    endtask

    // Reset values: two taps cycle, the timeout then starts over
    task automatic test_reset_settings();
        press_key(1, 2, 1'b0, 0);
        press_key(1, 2, 1'b0, int'(COMMIT_RESET) + 2);
        press_key(1, 1, 1'b0, 0);
    endtask

    // Every key once, fresh each time, several columns low at random
    task automatic test_every_key();
        int k;
        set_config(8'd1, 12'd0);
        for (k = 0; k < 12; k++)
            press_key(k, $urandom_range(0, 2), 1'b0, 1);
    endtask

    // Repeated taps run through letters, digit and wrap
    task automatic test_tap_cycles();
        set_config(8'd2, IDLE_MAX);
        repeat (6) press_key(6, 0, 1'b0, 0);
        repeat (6) press_key(8, 0, 1'b0, 0);
        repeat (5) press_key(1, 0, 1'b0, 0);
        repeat (2) press_key(0, 0, 1'b0, 0);
        repeat (2) press_key(11, 0, 1'b0, 0);
        press_key(9, 0, 1'b0, 0);
        press_key(10, 0, 1'b0, 0);
    endtask

    // Bouncing contacts during both debounce windows
    task automatic test_bounce();
        set_config(8'd6, 12'd3);
        press_key(4, 1, 1'b1, 0);
        press_key(4, 0, 1'b1, 2);
        press_key(7, 2, 1'b1, 5);
        press_key(2, 0, 1'b1, 0);
    endtask

    // Largest and zero debounce, zero and one commit timeout
    task automatic test_register_extremes();
        set_config(DEB_MAX, 12'd1);
        press_key(3, 1, 1'b0, 2);
        set_config(8'd0, 12'd0);
        press_key(7, 0, 1'b0, 0);
        press_key(7, 0, 1'b0, 0);
        set_config(8'd1, 12'd1);
        press_key(5, 0, 1'b0, 0);
        press_key(5, 0, 1'b0, 0);
    endtask

    // Random typing over changing settings, with noise ticks mixed in
    task automatic test_random_typing();
        int start;
        int presses_left;
        int key;
        int prev_key;
        int gap;
        int r;
        logic [DEB_W-1:0]  deb;
        logic [IDLE_W-1:0] commit;
        start = n_ticks;
        presses_left = 0;
        prev_key = 0;
        while (n_ticks - start < 700)
        begin
            if (n_ticks - start > 550)
                idling_on = 1'b0;
            if (presses_left == 0)
            begin
                r = $urandom_range(0, 9);
                deb = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom_range(10, 30))
                                                  : 8'($urandom_range(1, 5));
                r = $urandom_range(0, 9);
                commit = (r == 0) ? 12'd0 : (r == 1) ? IDLE_MAX
                       : (r < 4) ? 12'($urandom_range(1, 3)) : 12'($urandom_range(4, 40));
                set_config(deb, commit);
                presses_left = $urandom_range(6, 12);
            end
            if ($urandom_range(0, 6) == 0)
            begin
                // noise: arbitrary lines in whatever phase the scanner is in
                repeat ($urandom_range(1, 6)) send_tick(LINES_W'($urandom_range(0, 7)));
            end
            else
            begin
                key = ($urandom_range(0, 1) == 1) ? prev_key : $urandom_range(0, 11);
                if ($urandom_range(0, 2) == 0)
                    gap = (cfg_commit > 12'd78) ? 80 : int'(cfg_commit) + $urandom_range(0, 2);
                else
                    gap = $urandom_range(0, 3);
                press_key(key, $urandom_range(0, 4), $urandom_range(0, 3) == 0, gap);
                prev_key = key;
                presses_left--;
            end
        end
    endtask

    // Output side: random stall bursts while idling is on
    initial
    begin : out_ready_drive
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 16);
            if (idling_on && $urandom_range(0, 3) == 0)
            begin
                repeat (n)
                begin
                    @(negedge clk);
                    out_ch.ready <= 1'b0;
                end
            end
            else
            begin
                repeat (n)
                begin
                    @(negedge clk);
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_results
        kpd_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: row_select %0d char_valid %0d char_code %0h",
                       out_ch.row_select, out_ch.char_valid, out_ch.char_code);
                n_fail++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.char_valid)
                    n_chars++;
                if (out_ch.row_select !== want.row_select)
                begin
                    $error("row_select: expected %0d, actual %0d",
                           want.row_select, out_ch.row_select);
                    n_fail++;
                end
                if (out_ch.char_valid !== want.char_valid)
                begin
                    $error("char_valid: expected %0d, actual %0d",
                           want.char_valid, out_ch.char_valid);
                    n_fail++;
                end
                if (out_ch.char_code !== want.char_code)
                begin
                    $error("char_code: expected %0h, actual %0h",
                           want.char_code, out_ch.char_code);
                    n_fail++;
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Sequence of tests
    initial
    begin : main_seq
        int guard;
        in_ch.valid        = 1'b0;
        in_ch.column_lines = LINES_IDLE;
        cfg_we    = 1'b0;
        cfg_index = CFG_DEBOUNCE;
        cfg_data  = '0;
        rst_n     = 1'b0;
        idling_on = 1'b1;
        n_fail = 0;
        n_ticks = 0;
        n_chars = 0;
        n_settings = 0;
        ph       = PH_SCAN;
        row_idx  = '0;
        lat_col  = '0;
        deb_cnt  = '0;
        idle_cnt = '0;
        last_key = NO_KEY;
        taps     = '0;
        cfg_deb    = DEBOUNCE_RESET;
        cfg_commit = COMMIT_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_every_key();
        test_tap_cycles();
        test_bounce();
        test_register_extremes();
        test_random_typing();

        // wind down: all results out, then check that none is missing
        @(negedge clk);
        in_ch.valid <= 1'b0;
        guard = 0;
        while (expected_q.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d results never arrived", expected_q.size());
            n_fail++;
        end

        $display("Covered %0d scan ticks under %0d register settings,", n_ticks, n_settings + 1);
        $display("with %0d decoded characters checked and %0d mismatches.", n_chars, n_fail);
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
